/* hdl/lrt_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, command codes and the payload word of the LRU route table.
// Used by lru_route_table_unit, its port checker and the testbench; depends on nothing else.
package lrt_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;

    localparam int KEY_W = 32;
    localparam int HOP_W = 32;
    localparam int CNT_W = 8;
    localparam int SEQ_W = 32;

    localparam int S_FIELDS_W = KEY_W + HOP_W + CNT_W + SEQ_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = HOP_W + CNT_W + SEQ_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int S_USER_W   = 3;
    localparam int M_USER_W   = 3;

    localparam int USR_HIT   = 0;
    localparam int USR_BAD   = 1;
    localparam int USR_EVICT = 2;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [RANK_W-1:0] OLDEST_RANK = RANK_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        CMD_ADD          = 3'd0,
        CMD_LOOKUP_VALID = 3'd1,
        CMD_LOOKUP_ANY   = 3'd2,
        CMD_TOUCH        = 3'd3,
        CMD_MARK_BAD     = 3'd4,
        CMD_FLUSH        = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [CNT_W-1:0] hops;
        logic [HOP_W-1:0] next_hop;
    } pay_t;

endpackage

/* hdl/lru_route_table_unit.sv */
`timescale 1ns / 1ps
// LRU route table: key memory, payload memory, recency ranks and the command sequencer.
// Depends on lrt_pkg.
//
// Usage: each input beat carries a command in s_axis_tuser and the key, next hop,
// hop count and network-order sequence number in s_axis_tdata. Every command gives
// exactly one result beat on the m_axis side: hit, bad and evicted flags in
// m_axis_tuser, next hop, hop count and host-order sequence number in m_axis_tdata.
// Lookup, touch and mark-bad misses, flushes and unknown commands give all-zero results.
// Add, lookup, touch and mark-bad walk the key memory one entry per cycle. An add or
// a miss goes from the walk through ST_RESOLVE to ST_OUT, and a lookup, touch or
// mark-bad hit also passes ST_FETCH; flush and unknown commands skip the walk.
// s_axis_tready rises again in the cycle after the result beat is loaded.
// One item is worked on at a time; s_axis_tready is high only between items.
// The result sits in an output register, so the next item is accepted while a
// result beat still waits for m_axis_tready. If that register is still full when
// the next result is ready, the sequencer holds it until the receiver takes the beat.
// Reset clears all valid marks, bad marks and ranks, so the table starts empty;
// the memories themselves are not cleared and need no clearing pass.
module lru_route_table_unit import lrt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // dest_addr, next_hop_in, hops_in, seq_net
    input  logic [S_USER_W-1:0] s_axis_tuser,  // cmd
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // next_hop_out, hops_out, seq_out
    output logic [M_USER_W-1:0] m_axis_tuser   // hit, entry_bad, evicted
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_FETCH,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [2:0]          cmd_reg;
    logic [KEY_W-1:0]    key_in_reg;
    pay_t                pay_in_reg;

    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_busy_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [KEY_W-1:0]    key_q_reg;
    pay_t                pay_q_reg;

    logic                match_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    old_idx_reg;

    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  bad_reg;
    logic [RANK_W-1:0]   rank_reg [ENTRIES];

    logic                res_hit_reg;
    logic                res_bad_reg;
    logic                res_evict_reg;
    pay_t                res_pay_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_USER_W-1:0] m_user_reg;

    logic [KEY_W-1:0]    key_mem [ENTRIES];
    pay_t                pay_mem [ENTRIES];

    logic [IDX_W-1:0]    slot;
    logic                slot_bad;
    logic                found_ok;
    logic                front_en;
    logic                mem_we;
    logic [RANK_W:0]     old_rank;
    logic                cmp_valid;
    logic                out_load;

    function automatic logic [SEQ_W-1:0] swap32(input logic [SEQ_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign cmp_valid = valid_reg[cmp_idx_reg];

    always_comb begin
        if (cmd_reg == CMD_ADD) begin
            slot = match_reg ? match_idx_reg : (free_reg ? free_idx_reg : old_idx_reg);
        end else begin
            slot = match_idx_reg;
        end
        slot_bad = bad_reg[slot];
        found_ok = match_reg && !((cmd_reg == CMD_LOOKUP_VALID) && slot_bad);
        mem_we   = (state_reg == ST_RESOLVE) && (cmd_reg == CMD_ADD);
        front_en = (state_reg == ST_RESOLVE)
                   && ((cmd_reg == CMD_ADD) || ((cmd_reg == CMD_TOUCH) && found_ok));
        out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
        if ((cmd_reg == CMD_ADD) && !match_reg && free_reg) begin
            old_rank = (RANK_W + 1)'(ENTRIES);
        end else begin
            old_rank = {1'b0, rank_reg[slot]};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[slot] <= key_in_reg;
            pay_mem[slot] <= pay_in_reg;
        end
        key_q_reg <= key_mem[rd_idx_reg];
        pay_q_reg <= pay_mem[slot];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            bad_reg     <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
            m_valid_reg <= 1'b0;
            rd_busy_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= M_DATA_W'(res_pay_reg);
                m_user_reg  <= {res_evict_reg, res_bad_reg, res_hit_reg};
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        cmd_reg             <= s_axis_tuser;
                        key_in_reg          <= s_axis_tdata[31:0];
                        pay_in_reg.next_hop <= s_axis_tdata[63:32];
                        pay_in_reg.hops     <= s_axis_tdata[71:64];
                        pay_in_reg.seq      <= swap32(s_axis_tdata[103:72]);
                        match_reg           <= 1'b0;
                        free_reg            <= 1'b0;
                        rd_idx_reg          <= '0;
                        cmp_vld_reg         <= 1'b0;
                        case (s_axis_tuser) inside
                            CMD_ADD, CMD_LOOKUP_VALID, CMD_LOOKUP_ANY, CMD_TOUCH,
                            CMD_MARK_BAD: begin
                                rd_busy_reg <= 1'b1;
                                state_reg   <= ST_SCAN;
                            end
                            default: begin
                                state_reg <= ST_RESOLVE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    cmp_vld_reg <= rd_busy_reg;
                    cmp_idx_reg <= rd_idx_reg;
                    if (rd_busy_reg) begin
                        if (rd_idx_reg == LAST_IDX) begin
                            rd_busy_reg <= 1'b0;
                        end else begin
                            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                        end
                    end
                    if (cmp_vld_reg) begin
                        if (cmp_valid && (key_q_reg == key_in_reg) && !match_reg) begin
                            match_reg     <= 1'b1;
                            match_idx_reg <= cmp_idx_reg;
                        end
                        if (!cmp_valid && !free_reg) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= cmp_idx_reg;
                        end
                        if (cmp_valid && (rank_reg[cmp_idx_reg] == OLDEST_RANK)) begin
                            old_idx_reg <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX) begin
                            state_reg <= ST_RESOLVE;
                        end
                    end
                end
                ST_RESOLVE: begin
                    case (cmd_reg) inside
                        CMD_ADD: begin
                            res_hit_reg     <= match_reg;
                            res_bad_reg     <= 1'b0;
                            res_evict_reg   <= !match_reg && !free_reg;
                            res_pay_reg     <= pay_in_reg;
                            valid_reg[slot] <= 1'b1;
                            bad_reg[slot]   <= 1'b0;
                            state_reg       <= ST_OUT;
                        end
                        CMD_LOOKUP_VALID, CMD_LOOKUP_ANY, CMD_TOUCH, CMD_MARK_BAD: begin
                            res_hit_reg   <= found_ok;
                            res_bad_reg   <= found_ok
                                             && (slot_bad || (cmd_reg == CMD_MARK_BAD));
                            res_evict_reg <= 1'b0;
                            res_pay_reg   <= '0;
                            if (found_ok && (cmd_reg == CMD_MARK_BAD)) begin
                                bad_reg[slot] <= 1'b1;
                            end
                            state_reg <= found_ok ? ST_FETCH : ST_OUT;
                        end
                        CMD_FLUSH: begin
                            res_hit_reg   <= 1'b0;
                            res_bad_reg   <= 1'b0;
                            res_evict_reg <= 1'b0;
                            res_pay_reg   <= '0;
                            valid_reg     <= '0;
                            for (int i = 0; i < ENTRIES; i++) begin
                                rank_reg[i] <= '0;
                            end
                            state_reg     <= ST_OUT;
                        end
                        default: begin
                            res_hit_reg   <= 1'b0;
                            res_bad_reg   <= 1'b0;
                            res_evict_reg <= 1'b0;
                            res_pay_reg   <= '0;
                            state_reg     <= ST_OUT;
                        end
                    endcase
                    if (front_en) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (IDX_W'(i) == slot) begin
                                rank_reg[i] <= '0;
                            end else if (valid_reg[i] && ({1'b0, rank_reg[i]} < old_rank)) begin
                                rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                            end
                        end
                    end
                end
                ST_FETCH: begin
                    res_pay_reg <= pay_q_reg;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/lrt_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for lru_route_table_unit and the bind that attaches it.
// Depends on lrt_pkg.
module lrt_checker import lrt_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [S_DATA_W-1:0] s_axis_tdata,
    input logic [S_USER_W-1:0] s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic [M_USER_W-1:0] m_axis_tuser
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // One item at a time: the input side closes right after a beat is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // An eviction only happens when the key was not found.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[USR_EVICT] && m_axis_tuser[USR_HIT]))
        else $error("evicted and hit both set");

    // The bad flag is reported only for a matched entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USR_BAD] |-> m_axis_tuser[USR_HIT])
        else $error("bad flag without a hit");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind lru_route_table_unit lrt_checker u_lrt_checker (.*);

/* tb/lru_route_table_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lru_route_table_unit: a directed table and random
// command streams, checked beat by beat against fixed results or a predictor of the route table.
// Depends on lrt_pkg and lru_route_table_unit.
module lru_route_table_unit_tb;
    import lrt_pkg::*;

    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int KEY_POOL_SIZE = 12;
    localparam int HOLD_AT_BEAT = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic             hit;
        logic             bad;
        logic [HOP_W-1:0] next_hop;
        logic [CNT_W-1:0] hops;
        logic [SEQ_W-1:0] seq;
        logic             evict;
    } route_res_t;

    typedef struct {
        logic [2:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [HOP_W-1:0] next_hop;
        logic [CNT_W-1:0] hops;
        logic [SEQ_W-1:0] seq_net;
        bit               typed;
        route_res_t       want;
    } route_row_t;

    localparam route_res_t NO_ROUTE = '0;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [S_USER_W-1:0] s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;

    logic [KEY_W-1:0]  rt_key   [ENTRIES];
    logic [HOP_W-1:0]  rt_hop   [ENTRIES];
    logic [CNT_W-1:0]  rt_cnt   [ENTRIES];
    logic [SEQ_W-1:0]  rt_seq   [ENTRIES];
    logic              rt_bad   [ENTRIES];
    logic              rt_valid [ENTRIES];
    logic [RANK_W-1:0] rt_rank  [ENTRIES];

    route_res_t expected_routes [$];
    route_row_t directed_rows [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int beats_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    lru_route_table_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic move_to_newest(input int slot);
        logic [RANK_W-1:0] old_rank;
        old_rank = rt_rank[slot];
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != slot && rt_valid[i] && rt_rank[i] < old_rank) begin
                rt_rank[i] = rt_rank[i] + 1'b1;
            end
        end
        rt_rank[slot] = '0;
    endtask

    task automatic route_table_step(input route_row_t row, output route_res_t res);
        int slot;
        slot = -1;
        res = NO_ROUTE;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && rt_valid[i] && rt_key[i] == row.key) begin
                slot = i;
            end
        end
        case (row.cmd)
            CMD_ADD: begin
                if (slot >= 0) begin
                    res.hit = 1'b1;
                    move_to_newest(slot);
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot < 0 && !rt_valid[i]) begin
                            slot = i;
                        end
                    end
                    if (slot >= 0) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (rt_valid[i]) begin
                                rt_rank[i] = rt_rank[i] + 1'b1;
                            end
                        end
                        rt_valid[slot] = 1'b1;
                        rt_rank[slot] = '0;
                    end else begin
                        // A full table gives up its oldest entry.
                        slot = 0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (rt_rank[i] > rt_rank[slot]) begin
                                slot = i;
                            end
                        end
                        res.evict = 1'b1;
                        move_to_newest(slot);
                    end
                end
                rt_key[slot] = row.key;
                rt_hop[slot] = row.next_hop;
                rt_cnt[slot] = row.hops;
                rt_seq[slot] = {row.seq_net[7:0], row.seq_net[15:8],
                                row.seq_net[23:16], row.seq_net[31:24]};
                rt_bad[slot] = 1'b0;
            end
            CMD_FLUSH: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    rt_valid[i] = 1'b0;
                    rt_rank[i] = '0;
                end
            end
            CMD_LOOKUP_VALID, CMD_LOOKUP_ANY, CMD_TOUCH, CMD_MARK_BAD: begin
                if (slot >= 0 && (row.cmd == CMD_LOOKUP_VALID) && rt_bad[slot]) begin
                    slot = -1;
                end
                if (slot >= 0) begin
                    res.hit = 1'b1;
                    if (row.cmd == CMD_TOUCH) begin
                        move_to_newest(slot);
                    end
                    if (row.cmd == CMD_MARK_BAD) begin
                        rt_bad[slot] = 1'b1;
                    end
                end
            end
            default: begin
                slot = -1;
            end
        endcase
        if (slot >= 0 && row.cmd != CMD_FLUSH) begin
            res.bad = rt_bad[slot];
            res.next_hop = rt_hop[slot];
            res.hops = rt_cnt[slot];
            res.seq = rt_seq[slot];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_route(input logic [M_USER_W-1:0] flags, input pay_t pay);
        route_res_t want;
        if (expected_routes.size() == 0) begin
            report_mismatch("unexpected beat", {flags, pay.next_hop[28:0]}, '0);
        end else begin
            want = expected_routes.pop_front();
            if (flags[USR_HIT] !== want.hit) begin
                report_mismatch("hit", 32'(flags[USR_HIT]), 32'(want.hit));
            end
            if (flags[USR_BAD] !== want.bad) begin
                report_mismatch("entry_bad", 32'(flags[USR_BAD]), 32'(want.bad));
            end
            if (flags[USR_EVICT] !== want.evict) begin
                report_mismatch("evicted", 32'(flags[USR_EVICT]), 32'(want.evict));
            end
            if (pay.next_hop !== want.next_hop) begin
                report_mismatch("next_hop_out", pay.next_hop, want.next_hop);
            end
            if (pay.hops !== want.hops) begin
                report_mismatch("hops_out", 32'(pay.hops), 32'(want.hops));
            end
            if (pay.seq !== want.seq) report_mismatch("seq_out", pay.seq, want.seq);
        end
    endtask

    // The receiver also owns the long hold-off that backs the table up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                compare_route(m_axis_tuser, m_axis_tdata);
                beats_seen++;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task automatic offer_beat(input route_row_t row);
        route_res_t res;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {row.seq_net, row.hops, row.next_hop, row.key};
        s_axis_tuser <= row.cmd;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        route_table_step(row, res);
        expected_routes.push_back(row.typed ? row.want : res);
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [HOP_W-1:0] next_hop, input logic [CNT_W-1:0] hops,
                           input logic [SEQ_W-1:0] seq_net, input bit typed,
                           input route_res_t want);
        route_row_t row;
        row.cmd = cmd;
        row.key = key;
        row.next_hop = next_hop;
        row.hops = hops;
        row.seq_net = seq_net;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    initial begin
        route_row_t row;
        int pick;
        for (int i = 0; i < ENTRIES; i++) begin
            rt_key[i] = '0;
            rt_hop[i] = '0;
            rt_cnt[i] = '0;
            rt_seq[i] = '0;
            rt_bad[i] = 1'b0;
            rt_valid[i] = 1'b0;
            rt_rank[i] = '0;
        end

        add_row(CMD_LOOKUP_VALID, 32'h0, $urandom, 8'h5A, $urandom, 1, NO_ROUTE);
        add_row(CMD_TOUCH, 32'hFFFF_FFFF, $urandom, 8'hA5, $urandom, 1, NO_ROUTE);
        add_row(CMD_MARK_BAD, 32'h0, $urandom, 8'h00, $urandom, 1, NO_ROUTE);
        add_row(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1,
                '{1'b0, 1'b0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0});
        add_row(CMD_ADD, 32'h0, 32'h0, 8'h00, 32'h0102_0304, 1,
                '{1'b0, 1'b0, 32'h0, 8'h00, 32'h0403_0201, 1'b0});
        add_row(CMD_ADD, 32'h0, 32'h1234_5678, 8'h80, 32'hAABB_CCDD, 1,
                '{1'b1, 1'b0, 32'h1234_5678, 8'h80, 32'hDDCC_BBAA, 1'b0});
        add_row(CMD_LOOKUP_ANY, 32'hFFFF_FFFF, 32'h0, 8'h00, 32'h0, 1,
                '{1'b1, 1'b0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0});
        add_row(CMD_MARK_BAD, 32'h0, 32'h0, 8'h00, 32'h0, 1,
                '{1'b1, 1'b1, 32'h1234_5678, 8'h80, 32'hDDCC_BBAA, 1'b0});
        add_row(CMD_LOOKUP_VALID, 32'h0, 32'h0, 8'h00, 32'h0, 1, NO_ROUTE);
        add_row(CMD_LOOKUP_ANY, 32'h0, 32'h0, 8'h00, 32'h0, 1,
                '{1'b1, 1'b1, 32'h1234_5678, 8'h80, 32'hDDCC_BBAA, 1'b0});
        add_row(CMD_TOUCH, 32'hFFFF_FFFF, 32'h0, 8'h00, 32'h0, 0, NO_ROUTE);
        for (int k = 1; k <= 6; k++) begin
            add_row(CMD_ADD, KEY_W'(k), $urandom, CNT_W'($urandom_range(255)), $urandom,
                    0, NO_ROUTE);
        end
        add_row(CMD_ADD, 32'd7, $urandom, CNT_W'($urandom_range(255)), $urandom, 0, NO_ROUTE);
        add_row(CMD_MARK_BAD, 32'd1, 32'h0, 8'h00, 32'h0, 0, NO_ROUTE);
        add_row(CMD_ADD, 32'd1, $urandom, CNT_W'($urandom_range(255)), $urandom, 0, NO_ROUTE);
        add_row(CMD_TOUCH, 32'd2, 32'h0, 8'h00, 32'h0, 0, NO_ROUTE);
        add_row(CMD_ADD, 32'd8, $urandom, CNT_W'($urandom_range(255)), $urandom, 0, NO_ROUTE);
        add_row(CMD_RSVD_6, 32'd2, $urandom, 8'hFF, $urandom, 1, NO_ROUTE);
        add_row(CMD_RSVD_7, 32'd8, $urandom, 8'hFF, $urandom, 1, NO_ROUTE);
        add_row(CMD_FLUSH, 32'd0, 32'h0, 8'h00, 32'h0, 1, NO_ROUTE);
        add_row(CMD_LOOKUP_ANY, 32'hFFFF_FFFF, 32'h0, 8'h00, 32'h0, 1, NO_ROUTE);
        add_row(CMD_ADD, 32'd5, $urandom, CNT_W'($urandom_range(255)), $urandom, 0, NO_ROUTE);

        wait (aresetn === 1'b1);
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            offer_beat(directed_rows[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
                default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
            endcase
            key_pool[0] = 32'h0;
            key_pool[1] = 32'hFFFF_FFFF;
            for (int i = 2; i < KEY_POOL_SIZE; i++) begin
                key_pool[i] = $urandom;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 35)      row.cmd = CMD_ADD;
                else if (pick < 50) row.cmd = CMD_LOOKUP_VALID;
                else if (pick < 65) row.cmd = CMD_LOOKUP_ANY;
                else if (pick < 78) row.cmd = CMD_TOUCH;
                else if (pick < 97) row.cmd = CMD_MARK_BAD;
                else                row.cmd = CMD_FLUSH;
                row.key = ($urandom_range(9) == 0) ? $urandom
                          : key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
                row.next_hop = $urandom;
                row.hops = CNT_W'($urandom_range(255));
                row.seq_net = $urandom;
                row.typed = 1'b0;
                row.want = NO_ROUTE;
                offer_beat(row);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_routes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
